// ===== sv/flmr_pkg.sv =====
// ----------------------------------------------------------------------------
// flmr_pkg
// shared types and constants of the folded linear model rmse scorer
// ----------------------------------------------------------------------------
package flmr_pkg;

   typedef enum logic [2:0] {
      KIND_WEIGHT = 3'd0,
      KIND_BIAS   = 3'd1,
      KIND_BIT    = 3'd2,
      KIND_MOL    = 3'd3,
      KIND_SET    = 3'd4
   } kind_type;

   localparam logic [0:0] CSR_FOLD_SIZE = 1'b0;
   localparam logic [10:0] FOLD_RESET = 11'd1024;

   localparam int SUM_W = 48;
   localparam int OUT_W = 40;
   localparam int SQ_W  = 64;

   typedef struct packed {
      logic start_fold;
      logic start_div;
      logic start_root;
      logic do_weight;
      logic do_bias;
      logic do_mac;
      logic do_mol;
      logic do_set;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic fold_done;
      logic div_done;
      logic root_done;
      logic empty;
   } sts_type;

endpackage

// ===== sv/flmr_if.sv =====
// ----------------------------------------------------------------------------
// flmr_req_if / flmr_rsp_if
// valid/ready channels for input and result items
// ----------------------------------------------------------------------------
interface flmr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [9:0]  weight_index;
   logic signed [18:0] weight_value;
   logic [31:0] bit_number;
   logic [7:0]  bit_count;
   logic signed [23:0] expt_value;
   modport source (output valid, kind, weight_index, weight_value, bit_number,
                   bit_count, expt_value, input ready);
   modport sink (input valid, kind, weight_index, weight_value, bit_number,
                 bit_count, expt_value, output ready);
endinterface

interface flmr_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic signed [39:0] prediction;
   logic signed [39:0] residual;
   logic [31:0] rmse;
   logic        empty_set;
   logic        sum_saturated;
   modport source (output valid, result_kind, prediction, residual, rmse,
                   empty_set, sum_saturated, input ready);
   modport sink (input valid, result_kind, prediction, residual, rmse,
                 empty_set, sum_saturated, output ready);
endinterface

// ===== sv/folded_linear_model_rmse.sv =====
// ----------------------------------------------------------------------------
// folded_linear_model_rmse
// linear model scorer on folded fingerprints with set rmse
// ----------------------------------------------------------------------------
// weight and bias items finish at accept; a bit event runs the bit-serial
// fold, ram read, multiply and accumulate
// end of molecule goes through ST_OUT before its result item is valid
// end of set runs 64 divider steps and 32 root steps; an empty set skips both
// synchronous active-high reset clears sums, bias and tally and sets fold size
// to 1024; the weight ram is not cleared
module folded_linear_model_rmse import flmr_pkg::*; #(
   parameter int WEIGHT_SLOTS  = 1024,
   parameter int MAX_MOLECULES = 65536
) (
   input  logic         clock,
   input  logic         reset,
   flmr_req_if.sink     req,
   flmr_rsp_if.source   rsp,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic [10:0] fold_ff;
   cmd_type cmd;
   sts_type sts;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_FOLD_SIZE) ? 32'(fold_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= FOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == CSR_FOLD_SIZE) begin
         fold_ff <= csr_pwdata[10:0];
      end
   end

   flmr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_kind(req.kind), .in_ready(req.ready),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .cmd(cmd), .sts(sts));

   flmr_dp #(.WEIGHT_SLOTS(WEIGHT_SLOTS), .MAX_MOLECULES(MAX_MOLECULES)) u_dp (
      .clock(clock), .reset(reset), .fold_size(fold_ff),
      .weight_index(req.weight_index), .weight_value(req.weight_value),
      .bit_number(req.bit_number), .bit_count(req.bit_count),
      .expt_value(req.expt_value), .cmd(cmd), .sts(sts),
      .result_kind(rsp.result_kind), .prediction(rsp.prediction),
      .residual(rsp.residual), .rmse(rsp.rmse), .empty_set(rsp.empty_set),
      .sum_saturated(rsp.sum_saturated));
endmodule

// ===== sv/flmr_ram.sv =====
// ----------------------------------------------------------------------------
// flmr_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module flmr_ram #(
   parameter int WIDTH = 19,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

// ===== sv/flmr_ctrl.sv =====
// ----------------------------------------------------------------------------
// flmr_ctrl
// sequencer for one item at a time
// ----------------------------------------------------------------------------
module flmr_ctrl import flmr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  logic [2:0] in_kind,
   output logic       in_ready,
   output logic       out_valid,
   input  logic       out_ready,
   output cmd_type    cmd,
   input  sts_type    sts
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_FOLD, ST_READ, ST_MUL, ST_MAC, ST_DIV, ST_ROOT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   assign in_ready  = (state_ff == ST_IDLE) && !(out_valid_ff && !out_ready);
   assign out_valid = out_valid_ff;

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !out_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (in_valid && in_ready) begin
               case (in_kind)
                  KIND_WEIGHT: cmd.do_weight = 1'b1;
                  KIND_BIAS:   cmd.do_bias = 1'b1;
                  KIND_BIT: begin
                     cmd.start_fold = 1'b1;
                     state_in = ST_FOLD;
                  end
                  KIND_MOL: begin
                     cmd.do_mol = 1'b1;
                     state_in = ST_OUT;
                  end
                  KIND_SET: begin
                     cmd.start_div = 1'b1;
                     state_in = ST_DIV;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FOLD: if (sts.fold_done) state_in = ST_READ;
         ST_READ: state_in = ST_MUL;
         ST_MUL: state_in = ST_MAC;
         ST_MAC: begin
            cmd.do_mac = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (sts.empty) begin
               state_in = ST_OUT;
            end else if (sts.div_done) begin
               cmd.start_root = 1'b1;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: if (sts.root_done) state_in = ST_OUT;
         ST_OUT: begin
            if (!out_valid_ff) begin
               cmd.load_out = 1'b1;
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule

// ===== sv/flmr_dp.sv =====
// ----------------------------------------------------------------------------
// flmr_dp
// datapath: fold, weight store, accumulators, divider and root
// ----------------------------------------------------------------------------
module flmr_dp import flmr_pkg::*; #(
   parameter int WEIGHT_SLOTS  = 1024,
   parameter int MAX_MOLECULES = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [10:0]        fold_size,
   input  logic [9:0]         weight_index,
   input  logic signed [18:0] weight_value,
   input  logic [31:0]        bit_number,
   input  logic [7:0]         bit_count,
   input  logic signed [23:0] expt_value,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic               result_kind,
   output logic signed [39:0] prediction,
   output logic signed [39:0] residual,
   output logic [31:0]        rmse,
   output logic               empty_set,
   output logic               sum_saturated
);
   localparam int AW = $clog2(WEIGHT_SLOTS);
   localparam int TW = $clog2(MAX_MOLECULES + 1);
   localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0] OMAX = SUM_W'({1'b0, {(OUT_W-1){1'b1}}});
   localparam logic signed [SUM_W-1:0] OMIN = -OMAX - SUM_W'(1);
   localparam logic [TW-1:0] TMAX = TW'(MAX_MOLECULES);

   logic signed [18:0] bias_ff;
   logic signed [SUM_W-1:0] msum_ff;
   logic [SQ_W-1:0] sqsum_ff;
   logic [TW-1:0] tally_ff;
   logic sat_ff;

   // fold: restoring remainder, one bit a cycle
   logic [16:0] fold_w;
   logic [31:0] fq_ff;
   logic [16:0] frem_ff;
   logic [5:0]  fcnt_ff;
   logic [7:0]  cnt_ff;
   logic [16:0] fsh;
   assign fold_w = (fold_size == 11'd0 || 32'(fold_size) > 32'(WEIGHT_SLOTS))
                   ? 17'(WEIGHT_SLOTS) : 17'(fold_size);
   assign fsh = {frem_ff[15:0], fq_ff[31]};

   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= '0;
      end else if (cmd.start_fold) begin
         fcnt_ff <= 6'd32;
      end else if (fcnt_ff != 6'd0) begin
         fcnt_ff <= fcnt_ff - 6'd1;
      end
      if (cmd.start_fold) begin
         fq_ff   <= bit_number;
         frem_ff <= '0;
         cnt_ff  <= bit_count;
      end else if (fcnt_ff != 6'd0) begin
         fq_ff   <= {fq_ff[30:0], 1'b0};
         frem_ff <= (fsh >= fold_w) ? fsh - fold_w : fsh;
      end
   end
   assign sts.fold_done = (fcnt_ff == 6'd1);

   logic [AW-1:0] ram_addr;
   logic [18:0] ram_q;
   assign ram_addr = cmd.do_weight ? AW'(weight_index) : AW'(frem_ff);
   flmr_ram #(.WIDTH(19), .DEPTH(WEIGHT_SLOTS)) u_ram (
      .clock(clock),
      .wr_en(cmd.do_weight && 32'(weight_index) < 32'(WEIGHT_SLOTS)),
      .addr(ram_addr), .wr_data(weight_value), .rd_data(ram_q));

   logic signed [27:0] prod_ff;
   always_ff @(posedge clock) begin
      prod_ff <= $signed({1'b0, cnt_ff}) * $signed(ram_q);
   end

   logic signed [SUM_W:0] macs;
   assign macs = {msum_ff[SUM_W-1], msum_ff} + (SUM_W+1)'(prod_ff);

   // molecule close
   logic signed [SUM_W:0] pr_raw;
   logic signed [SUM_W-1:0] pr_c;
   logic signed [SUM_W:0] rs_raw;
   logic signed [SUM_W-1:0] rs_c;
   logic [SUM_W-1:0] mag;
   logic [SQ_W-1:0] sq;
   logic [SQ_W:0] sqs;
   logic ps, rsat, sqsat;
   always_comb begin
      pr_raw = {msum_ff[SUM_W-1], msum_ff} + (SUM_W+1)'(bias_ff);
      ps = 1'b0;
      if (pr_raw > (SUM_W+1)'(OMAX)) begin
         pr_c = OMAX; ps = 1'b1;
      end else if (pr_raw < (SUM_W+1)'(OMIN)) begin
         pr_c = OMIN; ps = 1'b1;
      end else begin
         pr_c = pr_raw[SUM_W-1:0];
      end
      rs_raw = {pr_c[SUM_W-1], pr_c} - (SUM_W+1)'(expt_value);
      rsat = 1'b0;
      if (rs_raw > (SUM_W+1)'(OMAX)) begin
         rs_c = OMAX; rsat = 1'b1;
      end else if (rs_raw < (SUM_W+1)'(OMIN)) begin
         rs_c = OMIN; rsat = 1'b1;
      end else begin
         rs_c = rs_raw[SUM_W-1:0];
      end
      mag = rs_c[SUM_W-1] ? -rs_c : rs_c;
      sqsat = (mag[SUM_W-1:32] != '0);
      sq = sqsat ? '1 : mag[31:0] * mag[31:0];
      sqs = {1'b0, sqsum_ff} + {1'b0, sq};
   end

   // divider: quotient of error sum by tally, one bit a cycle
   logic [SQ_W-1:0] dq_ff;
   logic [TW:0]     dr_ff;
   logic [6:0]      dcnt_ff;
   logic [TW:0]     dsh;
   assign dsh = {dr_ff[TW-1:0], dq_ff[SQ_W-1]};
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.start_div) begin
         dcnt_ff <= 7'd64;
      end else if (dcnt_ff != 7'd0) begin
         dcnt_ff <= dcnt_ff - 7'd1;
      end
      if (cmd.start_div) begin
         dq_ff <= sqsum_ff;
         dr_ff <= '0;
      end else if (dcnt_ff != 7'd0) begin
         if (dsh >= {1'b0, tally_ff}) begin
            dr_ff <= dsh - {1'b0, tally_ff};
            dq_ff <= {dq_ff[SQ_W-2:0], 1'b1};
         end else begin
            dr_ff <= dsh;
            dq_ff <= {dq_ff[SQ_W-2:0], 1'b0};
         end
      end
   end
   assign sts.div_done = (dcnt_ff == 7'd0);
   assign sts.empty = (tally_ff == '0);

   // square root: two bits a cycle
   logic [SQ_W-1:0] rv_ff;
   logic [SQ_W-1:0] rr_ff;
   logic [SQ_W-1:0] rb_ff;
   logic [5:0] rcnt_ff;
   logic [SQ_W-1:0] rt;
   assign rt = rr_ff + rb_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rcnt_ff <= '0;
      end else if (cmd.start_root) begin
         rcnt_ff <= 6'd32;
      end else if (rcnt_ff != 6'd0) begin
         rcnt_ff <= rcnt_ff - 6'd1;
      end
      if (cmd.start_root) begin
         rv_ff <= dq_ff;
         rr_ff <= '0;
         rb_ff <= SQ_W'(1) << 62;
      end else if (rcnt_ff != 6'd0) begin
         if (rv_ff >= rt) begin
            rv_ff <= rv_ff - rt;
            rr_ff <= (rr_ff >> 1) + rb_ff;
         end else begin
            rr_ff <= rr_ff >> 1;
         end
         rb_ff <= rb_ff >> 2;
      end
   end
   assign sts.root_done = (rcnt_ff == 6'd1);

   logic mol_sat;
   assign mol_sat = ps | rsat | sqsat | sqs[SQ_W] | (tally_ff >= TMAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff  <= '0;
         msum_ff  <= '0;
         sqsum_ff <= '0;
         tally_ff <= '0;
         sat_ff   <= 1'b0;
      end else begin
         if (cmd.do_bias) bias_ff <= weight_value;
         if (cmd.do_mac) begin
            if (macs > (SUM_W+1)'(SMAX)) begin
               msum_ff <= SMAX; sat_ff <= 1'b1;
            end else if (macs < (SUM_W+1)'(SMIN)) begin
               msum_ff <= SMIN; sat_ff <= 1'b1;
            end else begin
               msum_ff <= macs[SUM_W-1:0];
            end
         end
         if (cmd.do_mol) begin
            sqsum_ff <= sqs[SQ_W] ? '1 : sqs[SQ_W-1:0];
            tally_ff <= (tally_ff >= TMAX) ? TMAX : tally_ff + TW'(1);
            msum_ff  <= '0;
            sat_ff   <= sat_ff | mol_sat;
         end
         if (cmd.load_out && result_kind) begin
            msum_ff  <= '0;
            sqsum_ff <= '0;
            tally_ff <= '0;
            sat_ff   <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.do_mol) begin
         result_kind   <= 1'b0;
         prediction    <= pr_c[OUT_W-1:0];
         residual      <= rs_c[OUT_W-1:0];
         rmse          <= '0;
         empty_set     <= 1'b0;
         sum_saturated <= sat_ff | mol_sat;
      end else if (cmd.start_div) begin
         result_kind   <= 1'b1;
         prediction    <= '0;
         residual      <= '0;
         rmse          <= '0;
         empty_set     <= (tally_ff == '0);
         sum_saturated <= sat_ff;
      end else if (sts.root_done) begin
         rmse <= (rv_ff >= rt) ? 32'((rr_ff >> 1) + rb_ff) : 32'(rr_ff >> 1);
      end
   end
endmodule

// ===== sv/flmr_checker.sv =====
// ----------------------------------------------------------------------------
// flmr_checker
// port-level checks of the scorer
// ----------------------------------------------------------------------------
module flmr_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_result_kind,
   input logic [39:0] rsp_prediction,
   input logic [31:0] rsp_rmse,
   input logic rsp_empty_set,
   input logic csr_pready
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_prediction))
      else $error("result dropped while stalled");
   a_mol_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_result_kind |-> rsp_rmse == 32'd0 && !rsp_empty_set)
      else $error("molecule item carries set fields");
   a_set_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind |-> rsp_prediction == 40'd0)
      else $error("set item carries prediction");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_set |-> rsp_rmse == 32'd0)
      else $error("empty set with nonzero rmse");
   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind folded_linear_model_rmse flmr_checker u_chk (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_result_kind(rsp.result_kind), .rsp_prediction(rsp.prediction),
   .rsp_rmse(rsp.rmse), .rsp_empty_set(rsp.empty_set),
   .csr_pready(csr_pready));

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the folded linear model rmse scorer
// ----------------------------------------------------------------------------
// items go in from a queue through a valid/ready driver; an in-bench score
// model follows every accepted item and predicts the molecule and set results
// that a monitor checks in order. fold size is changed between phases over the
// csr port, and sender and receiver idle at several rates
// ----------------------------------------------------------------------------
module tb import flmr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  SLOTS = 1024;
   localparam int  MOL_LIMIT = 65536;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
   localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 1;
   localparam longint OUT_HI = 64'sh7F_FFFF_FFFF;
   localparam longint OUT_LO = -OUT_HI - 1;
   localparam logic signed [18:0] W_MAX = 19'sd131072;
   localparam logic signed [18:0] W_MIN = -19'sd131072;

   typedef struct {
      logic [2:0]         kind;
      logic [9:0]         weight_index;
      logic signed [18:0] weight_value;
      logic [31:0]        bit_number;
      logic [7:0]         bit_count;
      logic signed [23:0] expt_value;
   } score_item_t;

   typedef struct {
      logic               result_kind;
      logic signed [39:0] prediction;
      logic signed [39:0] residual;
      logic [31:0]        rmse;
      logic               empty_set;
      logic               sum_saturated;
   } score_result_t;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [2:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   flmr_req_if req ();
   flmr_rsp_if rsp ();

   folded_linear_model_rmse i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   score_item_t   items_to_send[$];
   score_result_t expected_results[$];

   // score model state
   logic signed [18:0] model_weights[SLOTS];
   logic signed [18:0] model_bias;
   longint             model_mol_sum;
   bit [63:0]          model_sq_sum;
   int                 model_tally;
   bit                 model_sat;
   int                 model_fold;

   // stimulus side shadow
   bit                 slot_written[SLOTS];
   int                 gen_fold;

   int  send_idle_pct, recv_stall_pct;
   int  hold_req, hold_left;
   int  errors, cycles, mols_checked, sets_checked, items_made;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.kind = KIND_WEIGHT;
      req.weight_index = '0;
      req.weight_value = '0;
      req.bit_number = '0;
      req.bit_count = '0;
      req.expt_value = '0;
      rsp.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      forever #4 clock = ~clock;
   end

   function automatic longint clamp_sum(longint v, longint lo, longint hi);
      if (v > hi) begin
         model_sat = 1'b1;
         return hi;
      end
      if (v < lo) begin
         model_sat = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic bit [63:0] int_root(bit [63:0] v);
      bit [63:0] root;
      bit [63:0] b;
      root = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= root + b) begin
            v = v - (root + b);
            root = (root >> 1) + b;
         end else begin
            root = root >> 1;
         end
         b = b >> 2;
      end
      return root;
   endfunction

   function automatic void score_item(score_item_t it);
      score_result_t r;
      longint pred, res, prod;
      bit [63:0] mag, sq;
      int f;
      r = '{default: '0};
      case (it.kind)
         KIND_WEIGHT: model_weights[it.weight_index] = it.weight_value;
         KIND_BIAS: model_bias = it.weight_value;
         KIND_BIT: begin
            f = (model_fold == 0 || model_fold > SLOTS) ? SLOTS : model_fold;
            prod = longint'(it.bit_count) * longint'(model_weights[it.bit_number % f]);
            model_mol_sum = clamp_sum(model_mol_sum + prod, SUM_LO, SUM_HI);
         end
         KIND_MOL: begin
            pred = clamp_sum(longint'(model_bias) + model_mol_sum, OUT_LO, OUT_HI);
            res = clamp_sum(pred - longint'(it.expt_value), OUT_LO, OUT_HI);
            mag = res < 0 ? -res : res;
            if (mag > 64'hFFFF_FFFF) begin
               sq = '1;
               model_sat = 1'b1;
            end else begin
               sq = mag * mag;
            end
            if (model_sq_sum > ~sq) begin
               model_sq_sum = '1;
               model_sat = 1'b1;
            end else begin
               model_sq_sum = model_sq_sum + sq;
            end
            if (model_tally >= MOL_LIMIT) begin
               model_tally = MOL_LIMIT;
               model_sat = 1'b1;
            end else begin
               model_tally++;
            end
            model_mol_sum = 0;
            r.prediction = pred[39:0];
            r.residual = res[39:0];
            r.sum_saturated = model_sat;
            expected_results.push_back(r);
         end
         KIND_SET: begin
            r.result_kind = 1'b1;
            r.empty_set = (model_tally == 0);
            if (model_tally != 0) r.rmse = int_root(model_sq_sum / model_tally);
            r.sum_saturated = model_sat;
            expected_results.push_back(r);
            model_mol_sum = 0;
            model_sq_sum = '0;
            model_tally = 0;
            model_sat = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      score_item_t it;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            it = items_to_send.pop_front();
            req.valid <= 1'b1;
            req.kind <= it.kind;
            req.weight_index <= it.weight_index;
            req.weight_value <= it.weight_value;
            req.bit_number <= it.bit_number;
            req.bit_count <= it.bit_count;
            req.expt_value <= it.expt_value;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // input monitor feeding the score model
   always @(posedge clock) begin
      score_item_t it;
      if (!reset && req.valid && req.ready) begin
         it.kind = req.kind;
         it.weight_index = req.weight_index;
         it.weight_value = req.weight_value;
         it.bit_number = req.bit_number;
         it.bit_count = req.bit_count;
         it.expt_value = req.expt_value;
         score_item(it);
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req > 0) begin
         rsp.ready <= 1'b0;
         hold_left <= hold_req;
         hold_req <= 0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      score_result_t e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (e.result_kind) sets_checked++;
            else mols_checked++;
            if (rsp.result_kind !== e.result_kind) begin
               $error("result_kind exp %0d got %0d", e.result_kind, rsp.result_kind);
               errors++;
            end
            if (rsp.prediction !== e.prediction) begin
               $error("prediction exp %0d got %0d", e.prediction, rsp.prediction);
               errors++;
            end
            if (rsp.residual !== e.residual) begin
               $error("residual exp %0d got %0d", e.residual, rsp.residual);
               errors++;
            end
            if (rsp.rmse !== e.rmse) begin
               $error("rmse exp %0d got %0d", e.rmse, rsp.rmse);
               errors++;
            end
            if (rsp.empty_set !== e.empty_set) begin
               $error("empty_set exp %0d got %0d", e.empty_set, rsp.empty_set);
               errors++;
            end
            if (rsp.sum_saturated !== e.sum_saturated) begin
               $error("sum_saturated exp %0d got %0d", e.sum_saturated, rsp.sum_saturated);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_item(logic [2:0] kind, logic [9:0] idx, logic signed [18:0] val,
                            logic [31:0] bitnum, logic [7:0] cnt, logic signed [23:0] expt);
      score_item_t it;
      it.kind = kind;
      it.weight_index = idx;
      it.weight_value = val;
      it.bit_number = bitnum;
      it.bit_count = cnt;
      it.expt_value = expt;
      items_to_send.push_back(it);
      items_made++;
   endtask

   function automatic logic signed [18:0] rand_weight();
      return 19'($signed($urandom_range(262144)) - 131072);
   endfunction

   task automatic put_weight(int slot, logic signed [18:0] val);
      push_item(KIND_WEIGHT, slot[9:0], val, $urandom, $urandom, $urandom);
      slot_written[slot] = 1'b1;
   endtask

   // writes the folded slot first if it was never loaded
   task automatic put_bit(logic [31:0] bitnum, logic [7:0] cnt);
      int slot;
      slot = bitnum % gen_fold;
      if (!slot_written[slot]) put_weight(slot, rand_weight());
      push_item(KIND_BIT, $urandom, $urandom, bitnum, cnt, $urandom);
   endtask

   task automatic put_mol(logic signed [23:0] expt);
      push_item(KIND_MOL, $urandom, $urandom, $urandom, $urandom, expt);
   endtask

   task automatic put_set();
      push_item(KIND_SET, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic random_molecule();
      int n;
      logic [31:0] b;
      logic [7:0] c;
      n = $urandom_range(6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(2))
            0: b = $urandom_range(2047);
            1: b = $urandom;
            default: b = 32'hFFFF_FFFF - $urandom_range(3);
         endcase
         c = ($urandom_range(3) == 0) ? 8'd1 : 8'($urandom);
         put_bit(b, c);
      end
      put_mol($urandom);
   endtask

   task automatic random_phase(int n);
      int made;
      made = items_made;
      while (items_made - made < n) begin
         case ($urandom_range(19))
            0: put_weight($urandom_range(SLOTS - 1), rand_weight());
            1: push_item(KIND_BIAS, $urandom, rand_weight(), $urandom, $urandom, $urandom);
            2: put_set();
            3: push_item(KIND_UNUSED_FIRST + 3'($urandom_range(2)), $urandom, $urandom,
                         $urandom, $urandom, $urandom);
            4: put_bit($urandom, $urandom);
            default: random_molecule();
         endcase
      end
      put_set();
   endtask

   task automatic drain();
      wait (items_to_send.size() == 0);
      @(posedge clock);
      while (req.valid) @(posedge clock);
      wait (expected_results.size() == 0);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_fold(int f);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 3'(CSR_FOLD_SIZE) << 2;
      csr_pwdata <= 32'(f);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      model_fold = f;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      gen_fold = (f == 0 || f > SLOTS) ? SLOTS : f;
   endtask

   initial begin
      int folds[4];
      int send_pct[4];
      int recv_pct[4];
      errors = 0;
      cycles = 0;
      mols_checked = 0;
      sets_checked = 0;
      items_made = 0;
      hold_req = 0;
      hold_left = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      model_bias = '0;
      model_mol_sum = 0;
      model_sq_sum = '0;
      model_tally = 0;
      model_sat = 1'b0;
      model_fold = FOLD_RESET;
      gen_fold = FOLD_RESET;
      foreach (model_weights[i]) model_weights[i] = '0;
      foreach (slot_written[i]) slot_written[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every kind, empty and open sets
      put_weight(0, W_MAX);
      put_weight(SLOTS - 1, W_MIN);
      push_item(KIND_BIAS, '0, W_MAX, '0, '0, '0);
      put_bit(32'd0, 8'd255);
      put_bit(32'hFFFF_FFFF, 8'd0);
      put_bit(32'hFFFF_FFFF, 8'd255);
      put_mol(24'sh800000);
      put_bit(32'd1024, 8'd1);
      put_mol(24'sh7FFFFF);
      put_set();
      put_set();
      for (int k = 0; k < 3; k++)
         push_item(KIND_UNUSED_FIRST + 3'(k), '1, '1, '1, '1, '1);
      put_bit(32'd0, 8'd7);
      put_set();
      // residual beyond the square range
      for (int k = 0; k < 130; k++) put_bit(32'd0, 8'd255);
      put_mol(24'sh800000);
      put_mol(24'sd0);
      put_set();
      drain();

      folds = '{100, 1024, 0, 0};
      folds[2] = $urandom_range(101, 1023);
      folds[3] = $urandom_range(100, 1024);
      send_pct = '{0, 57, 0, 6};
      recv_pct = '{0, 0, 57, 6};
      for (int p = 0; p < 4; p++) begin
         write_fold(folds[p]);
         send_idle_pct = send_pct[p];
         recv_stall_pct = recv_pct[p];
         if (p == 0) begin
            @(negedge clock);
            hold_req = 400;
         end
         random_phase(64);
         drain();
      end

      $display("checked %0d molecule and %0d set results over %0d items",
               mols_checked, sets_checked, items_made);
      $display("fold sizes 100 to 1024, saturation, empty sets, idle and stall phases");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/flmr_pkg.sv
sv/flmr_if.sv
sv/flmr_ram.sv
sv/flmr_ctrl.sv
sv/flmr_dp.sv
sv/folded_linear_model_rmse.sv
sv/flmr_checker.sv
test/tb.sv
